// ===== design/uct_pkg.sv =====
// Shared types and constants for the unicode stream transcoder.
package uct_pkg;

    typedef enum logic [2:0] {
        ENC_BINARY  = 3'd0,
        ENC_UTF8    = 3'd1,
        ENC_UTF16LE = 3'd2,
        ENC_UTF16BE = 3'd3,
        ENC_UTF32LE = 3'd4,
        ENC_UTF32BE = 3'd5
    } enc_t;

    localparam logic       REG_SRC_ENC  = 1'b0;
    localparam logic       REG_DEST_ENC = 1'b1;
    localparam logic [2:0] ENC_RESET    = 3'd1;

    localparam logic [31:0] CP_MAX       = 32'h0010_FFFF;
    localparam logic [31:0] SUPP_BASE    = 32'h0001_0000;
    localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;

    // Decoded code point handed from the decoder to the encoder.
    typedef struct packed {
        logic        valid;
        logic [31:0] value;
    } code_t;

    // Encoded character: bytes in send order, byte count 1..4, range flag.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            err;
    } encoded_t;

endpackage

// ===== design/uct_decode.sv =====
// Input register and source decoder with its sequence state.
module uct_decode
    import uct_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte,
    input  logic [2:0] src_enc,
    input  logic       src_wr,
    input  logic       take,
    output code_t      code
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic [31:0] partial_reg, partial_next;
    logic [1:0]  rem_reg, rem_next;
    logic [9:0]  high_reg, high_next;
    logic        await_reg, await_next;

    logic        prod;
    logic [31:0] cp;
    logic        consume;
    logic [31:0] pv;
    logic [15:0] unit;

    always_comb begin
        prod         = 1'b0;
        cp           = {24'd0, in_byte_reg};
        partial_next = partial_reg;
        rem_next     = rem_reg;
        high_next    = high_reg;
        await_next   = await_reg;
        pv           = 32'd0;
        unit         = 16'd0;
        case (src_enc)
            ENC_UTF8: begin
                if (rem_reg != 2'd0) begin
                    pv       = {partial_reg[25:0], in_byte_reg[5:0]};
                    rem_next = rem_reg - 2'd1;
                    if (rem_next == 2'd0) begin
                        prod         = 1'b1;
                        cp           = pv;
                        partial_next = 32'd0;
                    end else begin
                        partial_next = pv;
                    end
                end else if (in_byte_reg[7:5] == 3'b110) begin
                    partial_next = {27'd0, in_byte_reg[4:0]};
                    rem_next     = 2'd1;
                end else if (in_byte_reg[7:4] == 4'b1110) begin
                    partial_next = {28'd0, in_byte_reg[3:0]};
                    rem_next     = 2'd2;
                end else if (in_byte_reg[7:3] == 5'b11110) begin
                    partial_next = {29'd0, in_byte_reg[2:0]};
                    rem_next     = 2'd3;
                end else begin
                    prod = 1'b1;
                end
            end
            ENC_UTF16LE, ENC_UTF16BE: begin
                if (rem_reg == 2'd0) begin
                    partial_next = {24'd0, in_byte_reg};
                    rem_next     = 2'd1;
                end else begin
                    if (src_enc == ENC_UTF16BE) begin
                        unit = {partial_reg[7:0], in_byte_reg};
                    end else begin
                        unit = {in_byte_reg, partial_reg[7:0]};
                    end
                    partial_next = 32'd0;
                    rem_next     = 2'd0;
                    if (await_reg) begin
                        // low unit taken unchecked
                        prod       = 1'b1;
                        cp         = {12'd0, high_reg, unit[9:0]} + SUPP_BASE;
                        await_next = 1'b0;
                        high_next  = 10'd0;
                    end else if (unit[15:10] == HI_SURR_TAG) begin
                        high_next  = unit[9:0];
                        await_next = 1'b1;
                    end else begin
                        prod = 1'b1;
                        cp   = {16'd0, unit};
                    end
                end
            end
            ENC_UTF32LE, ENC_UTF32BE: begin
                if (rem_reg == 2'd0) begin
                    partial_next = {24'd0, in_byte_reg};
                    rem_next     = 2'd3;
                end else begin
                    if (src_enc == ENC_UTF32BE) begin
                        pv = {partial_reg[23:0], in_byte_reg};
                    end else begin
                        case (rem_reg)
                            2'd3:    pv = partial_reg | {16'd0, in_byte_reg, 8'd0};
                            2'd2:    pv = partial_reg | {8'd0, in_byte_reg, 16'd0};
                            default: pv = partial_reg | {in_byte_reg, 24'd0};
                        endcase
                    end
                    rem_next = rem_reg - 2'd1;
                    if (rem_next == 2'd0) begin
                        prod         = 1'b1;
                        cp           = pv;
                        partial_next = 32'd0;
                    end else begin
                        partial_next = pv;
                    end
                end
            end
            default: begin
                prod = 1'b1;
            end
        endcase
    end

    assign consume       = in_valid_reg && (!prod || take);
    assign s_ready       = !in_valid_reg || consume;
    assign code.valid    = in_valid_reg && prod;
    assign code.value    = cp;
    assign in_valid_next = (s_valid && s_ready) ? 1'b1 : (consume ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            partial_reg  <= 32'd0;
            rem_reg      <= 2'd0;
            high_reg     <= 10'd0;
            await_reg    <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (src_wr) begin
                partial_reg <= 32'd0;
                rem_reg     <= 2'd0;
                high_reg    <= 10'd0;
                await_reg   <= 1'b0;
            end else if (consume) begin
                partial_reg <= partial_next;
                rem_reg     <= rem_next;
                high_reg    <= high_next;
                await_reg   <= await_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte;
        end
    end

endmodule

// ===== design/uct_encode.sv =====
// Destination encoder: one code point to its byte sequence.
module uct_encode
    import uct_pkg::*;
(
    input  logic [31:0] cp,
    input  logic [2:0]  dest_enc,
    output encoded_t    enc
);

    logic [19:0] v;
    logic [15:0] hi_unit, lo_unit;

    assign v       = cp[19:0] - SUPP_BASE[19:0];
    assign hi_unit = {HI_SURR_TAG, v[19:10]};
    assign lo_unit = {LO_SURR_TAG, v[9:0]};

    always_comb begin
        enc.bytes = '0;
        enc.count = 3'd1;
        enc.err   = 1'b0;
        if (cp > CP_MAX) begin
            enc.err = 1'b1;
        end else begin
            case (dest_enc)
                ENC_UTF8: begin
                    if (cp < 32'h80) begin
                        enc.bytes[0] = cp[7:0];
                    end else if (cp < 32'h800) begin
                        enc.bytes[0] = {3'b110, cp[10:6]};
                        enc.bytes[1] = {2'b10, cp[5:0]};
                        enc.count    = 3'd2;
                    end else if (cp < SUPP_BASE) begin
                        enc.bytes[0] = {4'b1110, cp[15:12]};
                        enc.bytes[1] = {2'b10, cp[11:6]};
                        enc.bytes[2] = {2'b10, cp[5:0]};
                        enc.count    = 3'd3;
                    end else begin
                        enc.bytes[0] = {5'b11110, cp[20:18]};
                        enc.bytes[1] = {2'b10, cp[17:12]};
                        enc.bytes[2] = {2'b10, cp[11:6]};
                        enc.bytes[3] = {2'b10, cp[5:0]};
                        enc.count    = 3'd4;
                    end
                end
                ENC_UTF16LE: begin
                    if (cp < SUPP_BASE) begin
                        enc.bytes[0] = cp[7:0];
                        enc.bytes[1] = cp[15:8];
                        enc.count    = 3'd2;
                    end else begin
                        enc.bytes[0] = hi_unit[7:0];
                        enc.bytes[1] = hi_unit[15:8];
                        enc.bytes[2] = lo_unit[7:0];
                        enc.bytes[3] = lo_unit[15:8];
                        enc.count    = 3'd4;
                    end
                end
                ENC_UTF16BE: begin
                    if (cp < SUPP_BASE) begin
                        enc.bytes[0] = cp[15:8];
                        enc.bytes[1] = cp[7:0];
                        enc.count    = 3'd2;
                    end else begin
                        enc.bytes[0] = hi_unit[15:8];
                        enc.bytes[1] = hi_unit[7:0];
                        enc.bytes[2] = lo_unit[15:8];
                        enc.bytes[3] = lo_unit[7:0];
                        enc.count    = 3'd4;
                    end
                end
                ENC_UTF32LE: begin
                    enc.bytes = {cp[31:24], cp[23:16], cp[15:8], cp[7:0]};
                    enc.count = 3'd4;
                end
                ENC_UTF32BE: begin
                    enc.bytes = {cp[7:0], cp[15:8], cp[23:16], cp[31:24]};
                    enc.count = 3'd4;
                end
                default: begin
                    enc.bytes[0] = cp[7:0];
                end
            endcase
        end
    end

endmodule

// ===== design/uct_emit.sv =====
// Result buffer: holds one encoded character and sends it a byte per item.
module uct_emit
    import uct_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load_valid,
    input  encoded_t   enc,
    output logic       take,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_byte,
    output logic       m_last,
    output logic       m_err
);

    logic [3:0][7:0] byte_reg;
    logic [2:0]      cnt_reg;
    logic            err_reg;
    logic            load;

    assign take    = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_ready);
    assign load    = take && load_valid;
    assign m_valid = cnt_reg != 3'd0;
    assign m_byte  = byte_reg[0];
    assign m_last  = cnt_reg == 3'd1;
    assign m_err   = err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
        end else if (load) begin
            cnt_reg <= enc.count;
        end else if (m_valid && m_ready) begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= enc.bytes;
            err_reg  <= enc.err;
        end else if (m_valid && m_ready) begin
            byte_reg <= {8'd0, byte_reg[3:1]};
        end
    end

endmodule

// ===== design/unicode_stream_transcoder_top.sv =====
// Top level of the unicode stream transcoder.
//
// Input channel s_*: one raw source byte per item on s_tdata.
// Result channel m_*: one encoded byte per item on m_tdata; m_tlast marks the
// final byte of a character; m_tuser flags a code point above U+10FFFF, sent
// as a single item with zero data and m_tlast set.
// Configuration: cfg_wr_en with cfg_addr 0 sets the source encoding and
// clears any open sequence, cfg_addr 1 sets the destination encoding.
// Write only while no item is in flight.
// A byte that completes a character is decoded and encoded from the input
// register and loads the result buffer once that buffer can take it; its
// result bytes are then sent from the result buffer.
// Throughput: one item per cycle for items that yield zero or one result
// byte, while the receiver does not stall; an item that yields two or more
// bytes holds later input until the result channel sends its last byte.
// Reset: both encodings return to UTF-8, sequence state and buffers clear.
// When the receiver stalls, the result buffer and then the input register
// fill and s_tready drops; no item is lost.
module unicode_stream_transcoder_top
    import uct_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte
    output logic       m_tlast,
    output logic       m_tuser,    // range_error
    input  logic       cfg_wr_en,
    input  logic       cfg_addr,
    input  logic [2:0] cfg_wdata
);

    logic [2:0] src_reg;
    logic [2:0] dest_reg;
    logic       src_wr;
    logic       take;
    code_t      code;
    encoded_t   enc;

    assign src_wr = cfg_wr_en && (cfg_addr == REG_SRC_ENC);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg  <= ENC_RESET;
            dest_reg <= ENC_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_SRC_ENC) begin
                src_reg <= cfg_wdata;
            end
            if (cfg_addr == REG_DEST_ENC) begin
                dest_reg <= cfg_wdata;
            end
        end
    end

    uct_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_byte  (s_tdata),
        .src_enc (src_reg),
        .src_wr  (src_wr),
        .take    (take),
        .code    (code)
    );

    uct_encode u_encode (
        .cp       (code.value),
        .dest_enc (dest_reg),
        .enc      (enc)
    );

    uct_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (code.valid),
        .enc        (enc),
        .take       (take),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_byte     (m_tdata),
        .m_last     (m_tlast),
        .m_err      (m_tuser)
    );

`ifndef SYNTH
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'd0)
        else $error("range error item not a lone zero byte");

    a_char_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a character");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");
`endif

endmodule
